@@ rtl/mpq_pkg.sv @@
`default_nettype none

package mpq_pkg;

    // number of cells in the chain
    localparam int CAPACITY = 128;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // returned by a delete on an empty queue
    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    // command broadcast to every cell
    typedef struct packed {
        logic                      insert;
        logic                      delete;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    // what a cell shows to its neighbors
    typedef struct packed {
        logic                      valid;
        logic                      take;
        logic signed [VALUE_W-1:0] value;
    } t_link;

endpackage

`default_nettype wire

@@ rtl/mpq_req_if.sv @@
`default_nettype none

interface mpq_req_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      mode;
    logic signed [mpq_pkg::VALUE_W-1:0]        value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/mpq_rsp_if.sv @@
`default_nettype none

interface mpq_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [mpq_pkg::VALUE_W-1:0]        removed_value;
    logic        [mpq_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output removed_value, output status, input ready);
    modport sink   (input valid, input removed_value, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/mpq_cell.sv @@
`default_nettype none

module mpq_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mpq_pkg::t_cmd  i_cmd,
    input  wire mpq_pkg::t_link i_left,
    input  wire mpq_pkg::t_link i_right,
    output mpq_pkg::t_link      o_link
);

    logic                              r_valid;
    logic                              n_valid;
    logic signed [mpq_pkg::VALUE_W-1:0] r_value;
    logic signed [mpq_pkg::VALUE_W-1:0] n_value;
    logic                              c_take;

    // new value belongs here or further left; equal values stay ahead
    assign c_take = !r_valid || (i_cmd.value < r_value);

    // next contents: shift right on insert, shift left on delete
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_cmd.insert && c_take) begin
            if (i_left.take) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else begin
                n_valid = 1'b1;
                n_value = i_cmd.value;
            end
        end else if (i_cmd.delete) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stored value
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.take  = c_take;
    assign o_link.value = r_value;

endmodule

`default_nettype wire

@@ rtl/min_priority_queue_core.sv @@
// a request's response is registered and appears in the cycle after the request is accepted
// throughput: one request per cycle while the response side is ready; every cell updates in the same cycle
// the chain is kept sorted, smallest value in cell 0, so a delete reads cell 0 only
// an insert compares the new value in every cell at once and shifts the larger ones right
// reset (synchronous, active low) clears the occupancy flags and the response valid flag
// no clearing pass: the queue is ready in the first cycle after reset
`default_nettype none

module min_priority_queue_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mpq_req_if.sink    i_req,
    mpq_rsp_if.source  o_rsp
);

    mpq_pkg::t_link c_link [mpq_pkg::CAPACITY];
    mpq_pkg::t_cmd  c_cmd;
    logic [mpq_pkg::CAPACITY-1:0] c_valid;

    logic c_accept;
    logic c_full;
    logic c_empty;

    logic                                r_rsp_valid;
    logic                                n_rsp_valid;
    logic signed [mpq_pkg::VALUE_W-1:0]  r_removed_value;
    logic signed [mpq_pkg::VALUE_W-1:0]  n_removed_value;
    logic        [mpq_pkg::STATUS_W-1:0] r_status;
    logic        [mpq_pkg::STATUS_W-1:0] n_status;

    // request handshake, response register acts as the output stage
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign c_accept    = i_req.valid && i_req.ready;

    assign c_empty = !c_link[0].valid;
    assign c_full  = c_link[mpq_pkg::CAPACITY-1].valid;

    // command for the chain
    assign c_cmd.insert = c_accept && (i_req.mode == mpq_pkg::MODE_INSERT) && !c_full;
    assign c_cmd.delete = c_accept && (i_req.mode == mpq_pkg::MODE_DELETE) && !c_empty;
    assign c_cmd.value  = i_req.value;

    // chain of cells
    for (genvar g = 0; g < mpq_pkg::CAPACITY; g++) begin : g_cell
        mpq_pkg::t_link c_left;
        mpq_pkg::t_link c_right;

        if (g == 0) begin : g_first
            assign c_left = '0;
        end else begin : g_mid_l
            assign c_left = c_link[g-1];
        end

        if (g == mpq_pkg::CAPACITY - 1) begin : g_last
            assign c_right = '0;
        end else begin : g_mid_r
            assign c_right = c_link[g+1];
        end

        assign c_valid[g] = c_link[g].valid;

        mpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (c_cmd),
            .i_left  (c_left),
            .i_right (c_right),
            .o_link  (c_link[g])
        );
    end

    // response contents
    always_comb begin
        n_rsp_valid     = r_rsp_valid;
        n_removed_value = r_removed_value;
        n_status        = r_status;
        if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
        if (c_accept) begin
            n_rsp_valid = 1'b1;
            if (i_req.mode == mpq_pkg::MODE_INSERT) begin
                n_removed_value = '0;
                n_status        = c_full ? mpq_pkg::ST_FULL : mpq_pkg::ST_OK;
            end else if (c_empty) begin
                n_removed_value = mpq_pkg::EMPTY_VALUE;
                n_status        = mpq_pkg::ST_EMPTY;
            end else begin
                n_removed_value = c_link[0].value;
                n_status        = mpq_pkg::ST_OK;
            end
        end
    end

    // response valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        r_removed_value <= n_removed_value;
        r_status        <= n_status;
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.removed_value = r_removed_value;
    assign o_rsp.status        = r_status;

`ifndef ASSERT_OFF
    // occupied cells always form a contiguous run from cell 0
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((c_valid + {{(mpq_pkg::CAPACITY-1){1'b0}}, 1'b1}) & c_valid) == '0)
        else $error("occupied cells are not contiguous");

    // head of the chain holds the smallest value
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_link[1].valid |-> (c_link[0].value <= c_link[1].value))
        else $error("cell 0 is not the minimum");

    // a delete on a non-empty queue returns the old head
    a_delete_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_cmd.delete |=> (r_rsp_valid && (r_status == mpq_pkg::ST_OK)
                          && (r_removed_value == $past(c_link[0].value))))
        else $error("delete did not return the head value");

    // an insert into a full queue leaves the chain unchanged and reports full
    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && (i_req.mode == mpq_pkg::MODE_INSERT) && c_full)
        |=> ((r_status == mpq_pkg::ST_FULL) && $stable(c_valid)))
        else $error("insert into full queue mishandled");
`endif

endmodule

`default_nettype wire
